// ===== design/nearest_point_search_3d_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest point search unit
// Shared concurrent property forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_3D_UNIT_ASSERT_SVH
`define NEAREST_POINT_SEARCH_3D_UNIT_ASSERT_SVH

// Same-cycle implication
`define NPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Types, sizes and helpers shared by the nearest point search unit.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 20;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int OUT_IDX_W  = 10;
    localparam int NUM_CELLS  = 3;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ANSWER = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_PUT  = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_IDX_W-1:0] best_index;
        logic [COORD_W-1:0]   best_x;
        logic [COORD_W-1:0]   best_y;
        logic [COORD_W-1:0]   best_z;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_point;

    // One stored point on its way down the cell row
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [IDX_W-1:0]  idx;
        t_point            pt;
        logic [DIST_W-1:0] acc;
    } t_stream;

    // Map a store index onto the result index field (low bits, zero padded)
    function automatic logic [OUT_IDX_W-1:0] f_out_index(input logic [IDX_W-1:0] v);
        logic [OUT_IDX_W-1:0] r;
        r = '0;
        for (int b = 0; b < OUT_IDX_W; b++) begin
            if (b < IDX_W) begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

endpackage

// ===== design/nps_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_store
// Point memory with one write port and a scanning read port that streams
// the stored points, in store order, into the distance cell row.
// ----------------------------------------------------------------------------
module nps_store
    import nps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_point           i_wr_data,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_count,
    output t_stream          o_stream
);

    t_point mem [MAX_POINTS];

    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_vld;
    logic             r_last;
    logic [IDX_W-1:0] r_idx;
    t_point           r_rd_data;
    logic [CNT_W-1:0] last_cnt;
    logic             at_last;

    // Write loaded points
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_rd_idx];
        r_idx     <= r_rd_idx;
    end

    // Advance the scan address
    always_comb begin
        last_cnt = i_count - CNT_W'(1);
        at_last  = (r_rd_idx == last_cnt[IDX_W-1:0]);
        n_busy   = r_busy;
        n_rd_idx = r_rd_idx;
        if (i_start) begin
            n_busy   = 1'b1;
            n_rd_idx = '0;
        end else if (r_busy) begin
            if (at_last) begin
                n_busy = 1'b0;
            end else begin
                n_rd_idx = r_rd_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_idx <= '0;
            r_vld    <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_rd_idx <= n_rd_idx;
            r_vld    <= r_busy;
            r_last   <= r_busy && at_last;
        end
    end

    always_comb begin
        o_stream       = '0;
        o_stream.valid = r_vld;
        o_stream.last  = r_last;
        o_stream.idx   = r_idx;
        o_stream.pt    = r_rd_data;
        o_stream.acc   = '0;
    end

endmodule

// ===== design/nps_dist_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_dist_cell
// One cell of the distance row: adds the squared difference on its axis to
// the running distance of the point passing through, in registered steps.
// ----------------------------------------------------------------------------
module nps_dist_cell
    import nps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_axis   i_axis,
    input  t_point  i_query,
    input  t_stream i_stream,
    output t_stream o_stream
);

    t_stream            r_s1, r_s2, r_s3, n_s3;
    logic [COORD_W-1:0] r_diff;
    logic [SQ_W-1:0]    r_sq;
    logic [COORD_W-1:0] a_c, q_c, n_diff;

    // Pick this cell's axis
    always_comb begin
        case (i_axis)
            AXIS_X: begin
                a_c = i_stream.pt.x;
                q_c = i_query.x;
            end
            AXIS_Y: begin
                a_c = i_stream.pt.y;
                q_c = i_query.y;
            end
            AXIS_Z: begin
                a_c = i_stream.pt.z;
                q_c = i_query.z;
            end
            default: begin
                a_c = '0;
                q_c = '0;
            end
        endcase
        n_diff = (a_c > q_c) ? (a_c - q_c) : (q_c - a_c);
    end

    // Add the square to the running distance
    always_comb begin
        n_s3     = r_s2;
        n_s3.acc = r_s2.acc + DIST_W'(r_sq);
    end

    // Difference, square, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1 <= i_stream;
            r_s2 <= r_s1;
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
        r_sq   <= SQ_W'(r_diff) * SQ_W'(r_diff);
    end

    assign o_stream = r_s3;

endmodule

// ===== design/nps_best.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_best
// Keeps the nearest point seen so far in a scan; ties keep the earlier one.
// ----------------------------------------------------------------------------
module nps_best
    import nps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_stream          i_stream,
    output logic             o_done,
    output logic [IDX_W-1:0] o_idx,
    output t_point           o_pt
);

    logic              r_have;
    logic              r_done;
    logic [DIST_W-1:0] r_best_dist;
    logic [IDX_W-1:0]  r_best_idx;
    t_point            r_best_pt;
    logic              take;

    // Take the first point, then only strictly closer ones
    assign take = i_stream.valid && (!r_have || (i_stream.acc < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_stream.valid && i_stream.last;
            if (i_start) begin
                r_have <= 1'b0;
            end else if (i_stream.valid) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_dist <= i_stream.acc;
            r_best_idx  <= i_stream.idx;
            r_best_pt   <= i_stream.pt;
        end
    end

    assign o_done = r_done;
    assign o_idx  = r_best_idx;
    assign o_pt   = r_best_pt;

endmodule

// ===== design/nearest_point_search_3d_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_search_3d_unit
// Brute force nearest neighbor search over a store of loaded 3D points.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// Clear, load and unused ops, and a query on an empty store, go through S_PUT
// to the output register. For a query the single memory read port streams
// one stored point per cycle through three distance cells and the best tracker.
// Reset empties the store by zeroing the point count; no clearing pass is run.
// A new item is taken while a finished result waits; a result then waits for
// the output register before the next item is taken.
// ----------------------------------------------------------------------------
`include "nearest_point_search_3d_unit_assert.svh"

module nearest_point_search_3d_unit
    import nps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_point           r_query, n_query;
    t_out_item        r_res, n_res;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             in_xfer;
    logic             wr_en;
    logic             scan_start;
    logic             out_free;
    t_point           in_pt;
    t_stream          chain [NUM_CELLS+1];
    logic             best_done;
    logic [IDX_W-1:0] best_idx;
    t_point           best_pt;

    assign in_pt.x = i_in_item.pos_x;
    assign in_pt.y = i_in_item.pos_y;
    assign in_pt.z = i_in_item.pos_z;

    // Point store and scanner
    nps_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (in_pt),
        .i_start   (scan_start),
        .i_count   (r_count),
        .o_stream  (chain[0])
    );

    // Row of distance cells, one per axis
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        nps_dist_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_axis   (t_axis'(2'(k))),
            .i_query  (r_query),
            .i_stream (chain[k]),
            .o_stream (chain[k+1])
        );
    end

    // Nearest point tracker
    nps_best u_best (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scan_start),
        .i_stream (chain[NUM_CELLS]),
        .o_done   (best_done),
        .o_idx    (best_idx),
        .o_pt     (best_pt)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Next state and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_query     = r_query;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        wr_en       = 1'b0;
        scan_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res        = '0;
                    n_res.status = ST_DONE;
                    n_state      = S_PUT;
                    case (i_in_item.op)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_LOAD: begin
                            if (r_count >= CNT_W'(MAX_POINTS)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_query    = in_pt;
                                scan_start = 1'b1;
                                n_state    = S_SCAN;
                            end
                        end
                        default: begin
                            n_res.status = ST_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (best_done) begin
                    n_res.status     = ST_ANSWER;
                    n_res.best_index = f_out_index(best_idx);
                    n_res.best_x     = best_pt.x;
                    n_res.best_y     = best_pt.y;
                    n_res.best_z     = best_pt.z;
                    n_state          = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query <= n_query;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    `NPS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_POINTS), "point count above store size")
    `NPS_ASSERT_SAME(a_done_in_scan, i_clk, i_rst_n, best_done, r_state == S_SCAN, "scan finished outside a query")
    `NPS_ASSERT_NEXT(a_scan_enter, i_clk, i_rst_n, scan_start, r_state == S_SCAN, "query did not start a scan")
    `NPS_ASSERT_NEXT(a_put_loads, i_clk, i_rst_n, (r_state == S_PUT) && out_free, o_out_valid && (r_state == S_IDLE), "result not moved to output")

endmodule
